@@ sv/wsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants of the wav stream parser
// Transaction payloads of the byte and result channels, chunk tags and
// status codes.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // byte channel transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } byte_item_t;

    // result channel transaction
    typedef struct packed {
        logic [3:0]         status;
        logic signed [15:0] sample_value;
        logic               channel_index;
        logic [31:0]        sample_rate;
        logic [1:0]         num_channels;
        logic [4:0]         sample_bits;
    } result_item_t;

    // chunk tags, big-endian as they arrive
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // format checks
    localparam logic [15:0] PCM_CODE   = 16'd1;
    localparam logic [15:0] BITS_NARROW = 16'd8;
    localparam logic [15:0] BITS_WIDE  = 16'd16;
    localparam logic [15:0] CH_MONO    = 16'd1;
    localparam logic [15:0] CH_STEREO  = 16'd2;
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;

    // status codes
    localparam logic [3:0] ST_SAMPLE       = 4'd0;
    localparam logic [3:0] ST_HEADER_OK    = 4'd1;
    localparam logic [3:0] ST_BAD_RIFF     = 4'd2;
    localparam logic [3:0] ST_NO_FMT       = 4'd3;
    localparam logic [3:0] ST_NOT_PCM      = 4'd4;
    localparam logic [3:0] ST_NO_DATA      = 4'd5;
    localparam logic [3:0] ST_EMPTY_DATA   = 4'd6;
    localparam logic [3:0] ST_BAD_BITS     = 4'd7;
    localparam logic [3:0] ST_BAD_CHANNELS = 4'd8;

endpackage

@@ sv/wsp_parse.sv @@
// ----------------------------------------------------------------------------
// wsp_parse: byte-level parse state machine
// Holds the header parse state and turns one byte per step into at most
// one result; the result is combinational and registered by the caller.
// ----------------------------------------------------------------------------
module wsp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  wsp_pkg::byte_item_t  item,
    output logic                 res_valid,
    output wsp_pkg::result_item_t res
);

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HDR_FMT,
        PH_SKIP_FMT,
        PH_FMT_BODY,
        PH_HDR_DATA,
        PH_SKIP_DATA,
        PH_SAMPLES,
        PH_IDLE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [7:0]  low_reg, low_next;
    logic        toggle_reg, toggle_next;
    logic [31:0] left_reg, left_next;

    logic [7:0]  b;
    logic [31:0] hdr_tag;
    logic [31:0] hdr_len;
    logic        hdr_done;
    logic [31:0] skip_len;
    logic [3:0]  skip_fbc;
    logic        skip_done;
    logic [31:0] left_dec;
    logic [31:0] data_len;

    assign b = item.data_byte;

    // chunk header: four tag bytes then a little-endian length
    always_comb
    begin
        hdr_tag = tag_reg;
        hdr_len = (fbc_reg == 4'd0) ? 32'd0 : len_reg;
        if (fbc_reg < 4'd4)
        begin
            hdr_tag = {tag_reg[23:0], b};
        end
        else
        begin
            case (fbc_reg[1:0])
                2'd0:    hdr_len[7:0]   = b;
                2'd1:    hdr_len[15:8]  = b;
                2'd2:    hdr_len[23:16] = b;
                2'd3:    hdr_len[31:24] = b;
                default: hdr_len = len_reg;
            endcase
        end
        hdr_done = (fbc_reg >= 4'd7);
    end

    // skip countdown, then the pad byte if any
    always_comb
    begin
        skip_len  = (len_reg != 32'd0) ? len_reg - 32'd1 : len_reg;
        skip_fbc  = (len_reg != 32'd0) ? fbc_reg : 4'd0;
        skip_done = (skip_len == 32'd0) && (skip_fbc == 4'd0);
        left_dec  = (left_reg != 32'd0) ? left_reg - 32'd1 : left_reg;
        data_len  = (bits_reg == wsp_pkg::BITS_WIDE) ? {hdr_len[31:1], 1'b0} : hdr_len;
    end

    // next state and result for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        fbc_next    = fbc_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        fmt_next    = fmt_reg;
        chans_next  = chans_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        low_next    = low_reg;
        toggle_next = toggle_reg;
        left_next   = left_reg;
        res_valid   = 1'b0;
        res         = '0;

        case (phase_reg)
            PH_RIFF:
            begin
                tag_next = {tag_reg[23:0], b};
                fbc_next = fbc_reg + 4'd1;
                if ((fbc_reg == 4'd3 && tag_next != wsp_pkg::TAG_RIFF) ||
                    (fbc_reg == 4'd11 && tag_next != wsp_pkg::TAG_WAVE))
                begin
                    res_valid  = 1'b1;
                    res.status = wsp_pkg::ST_BAD_RIFF;
                    phase_next = PH_IDLE;
                end
                else if (fbc_reg >= 4'd11)
                begin
                    phase_next = PH_HDR_FMT;
                    fbc_next   = 4'd0;
                end
            end

            PH_HDR_FMT:
            begin
                tag_next = hdr_tag;
                len_next = hdr_len;
                fbc_next = fbc_reg + 4'd1;
                if (hdr_done)
                begin
                    fbc_next = 4'd0;
                    if (hdr_tag == wsp_pkg::TAG_FMT)
                    begin
                        phase_next = PH_FMT_BODY;
                    end
                    else if (hdr_len != 32'd0)
                    begin
                        phase_next = PH_SKIP_FMT;
                        fbc_next   = {3'd0, hdr_len[0]};
                    end
                end
            end

            PH_SKIP_FMT:
            begin
                len_next = skip_len;
                fbc_next = skip_fbc;
                if (skip_done)
                begin
                    phase_next = PH_HDR_FMT;
                end
            end

            PH_FMT_BODY:
            begin
                case (fbc_reg)
                    4'd0:    fmt_next   = {8'd0, b};
                    4'd1:    fmt_next   = {b, fmt_reg[7:0]};
                    4'd2:    chans_next = {8'd0, b};
                    4'd3:    chans_next = {b, chans_reg[7:0]};
                    4'd4:    rate_next  = {24'd0, b};
                    4'd5:    rate_next  = {rate_reg[31:16], b, rate_reg[7:0]};
                    4'd6:    rate_next  = {rate_reg[31:24], b, rate_reg[15:0]};
                    4'd7:    rate_next  = {b, rate_reg[23:0]};
                    4'd14:   bits_next  = {8'd0, b};
                    4'd15:   bits_next  = {b, bits_reg[7:0]};
                    default: fmt_next   = fmt_reg;
                endcase
                fbc_next = fbc_reg + 4'd1;
                if (fbc_reg == 4'd15)
                begin
                    fbc_next = 4'd0;
                    if (fmt_next != wsp_pkg::PCM_CODE)
                    begin
                        res_valid  = 1'b1;
                        res.status = wsp_pkg::ST_NOT_PCM;
                        phase_next = PH_IDLE;
                    end
                    else if (len_reg > wsp_pkg::FMT_BODY_LEN)
                    begin
                        // extra fmt bytes, plus pad when the length is odd
                        phase_next = PH_SKIP_DATA;
                        len_next   = len_reg - wsp_pkg::FMT_BODY_LEN;
                        fbc_next   = {3'd0, len_reg[0]};
                    end
                    else
                    begin
                        phase_next = PH_HDR_DATA;
                    end
                end
            end

            PH_HDR_DATA:
            begin
                tag_next = hdr_tag;
                len_next = hdr_len;
                fbc_next = fbc_reg + 4'd1;
                if (hdr_done)
                begin
                    fbc_next = 4'd0;
                    if (hdr_tag != wsp_pkg::TAG_DATA)
                    begin
                        if (hdr_len != 32'd0)
                        begin
                            phase_next = PH_SKIP_DATA;
                            fbc_next   = {3'd0, hdr_len[0]};
                        end
                    end
                    else if (hdr_len == 32'd0)
                    begin
                        res_valid  = 1'b1;
                        res.status = wsp_pkg::ST_EMPTY_DATA;
                        phase_next = PH_IDLE;
                    end
                    else if (bits_reg != wsp_pkg::BITS_NARROW &&
                             bits_reg != wsp_pkg::BITS_WIDE)
                    begin
                        res_valid  = 1'b1;
                        res.status = wsp_pkg::ST_BAD_BITS;
                        phase_next = PH_IDLE;
                    end
                    else if (chans_reg != wsp_pkg::CH_MONO &&
                             chans_reg != wsp_pkg::CH_STEREO)
                    begin
                        res_valid  = 1'b1;
                        res.status = wsp_pkg::ST_BAD_CHANNELS;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        left_next        = data_len;
                        toggle_next      = 1'b0;
                        phase_next       = (data_len != 32'd0) ? PH_SAMPLES : PH_IDLE;
                        res_valid        = 1'b1;
                        res.status       = wsp_pkg::ST_HEADER_OK;
                        res.sample_rate  = rate_reg;
                        res.num_channels = chans_reg[1:0];
                        res.sample_bits  = bits_reg[4:0];
                    end
                end
            end

            PH_SKIP_DATA:
            begin
                len_next = skip_len;
                fbc_next = skip_fbc;
                if (skip_done)
                begin
                    phase_next = PH_HDR_DATA;
                end
            end

            PH_SAMPLES:
            begin
                if (bits_reg == wsp_pkg::BITS_NARROW)
                begin
                    // unsigned byte recentered to signed, scaled to Q1.15
                    res_valid        = 1'b1;
                    res.sample_value = {b ^ 8'h80, 8'h00};
                end
                else if (fbc_reg == 4'd0)
                begin
                    low_next = b;
                    fbc_next = 4'd1;
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.sample_value = {b, low_reg};
                    fbc_next         = 4'd0;
                end
                if (res_valid)
                begin
                    res.status        = wsp_pkg::ST_SAMPLE;
                    res.channel_index = toggle_reg;
                    if (chans_reg == wsp_pkg::CH_STEREO)
                    begin
                        toggle_next = ~toggle_reg;
                    end
                end
                left_next = left_dec;
                if (left_dec == 32'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end

            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // end of file: report a truncated header, then restart
        if (item.end_of_file)
        begin
            if (!res_valid)
            begin
                case (phase_next)
                    PH_RIFF:
                    begin
                        res_valid  = 1'b1;
                        res.status = wsp_pkg::ST_BAD_RIFF;
                    end
                    PH_HDR_FMT, PH_SKIP_FMT, PH_FMT_BODY:
                    begin
                        res_valid  = 1'b1;
                        res.status = wsp_pkg::ST_NO_FMT;
                    end
                    PH_HDR_DATA, PH_SKIP_DATA:
                    begin
                        res_valid  = 1'b1;
                        res.status = wsp_pkg::ST_NO_DATA;
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
            phase_next  = PH_RIFF;
            fbc_next    = 4'd0;
            tag_next    = 32'd0;
            len_next    = 32'd0;
            fmt_next    = 16'd0;
            chans_next  = 16'd0;
            rate_next   = 32'd0;
            bits_next   = 16'd0;
            low_next    = 8'd0;
            toggle_next = 1'b0;
            left_next   = 32'd0;
        end
    end

    // parse state, updated once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            fbc_reg    <= 4'd0;
            tag_reg    <= 32'd0;
            len_reg    <= 32'd0;
            fmt_reg    <= 16'd0;
            chans_reg  <= 16'd0;
            rate_reg   <= 32'd0;
            bits_reg   <= 16'd0;
            low_reg    <= 8'd0;
            toggle_reg <= 1'b0;
            left_reg   <= 32'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            fmt_reg    <= fmt_next;
            chans_reg  <= chans_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            low_reg    <= low_next;
            toggle_reg <= toggle_next;
            left_reg   <= left_next;
        end
    end

endmodule

@@ sv/wav_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// wav_stream_parser_unit: streaming RIFF/WAVE PCM parser
// Input register, parse state machine and result register.
// ----------------------------------------------------------------------------
// Usage
//   byte channel: one byte of the wav file per transaction, end_of_file set
//   on the last byte. The parser checks RIFF/WAVE, reads fmt, finds data and
//   then reports one status transaction for the header (or an error code)
//   followed by one transaction per PCM sample, as Q1.15 with its channel.
//   result channel: zero or one transaction per input byte, in byte order.
//   Path: a byte taken is held in the input register, moves through the
//   combinational parse logic into the result register once that register
//   is free or being taken, and its result is shown from there until the
//   receiver takes it.
//   Throughput: one byte per clock while the receiver does not stall, with
//   the parse step combinational between the input and result registers.
//   Stall: while the result register holds an untaken transaction and the
//   receiver stalls, a held byte waits in the input register and byte_stall
//   is raised; an empty input register still takes one byte first.
//   Reset: the parser expects a RIFF header, both registers are empty.
//   After end_of_file the parser restarts for the next file.
// ----------------------------------------------------------------------------
module wav_stream_parser_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  wsp_pkg::byte_item_t   byte_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output wsp_pkg::result_item_t result_item
);

    logic                  in_valid_reg;
    wsp_pkg::byte_item_t   in_item_reg;
    logic                  out_valid_reg;
    wsp_pkg::result_item_t out_item_reg;

    logic                  advance;
    logic                  step_valid;
    wsp_pkg::result_item_t step_res;

    // held byte moves on when the result register is free or being taken
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;

    wsp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_item_reg <= byte_item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step_valid;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
        begin
            out_item_reg <= step_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

@@ tb/wav_stream_parser_check.sv @@
// ----------------------------------------------------------------------------
// wav_stream_parser_check: transaction predictor and comparator
// Watches the byte and result channels of the wav stream parser, runs its own
// parse state machine on every accepted byte and compares each accepted
// result transaction, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module wav_stream_parser_check (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic                  byte_stall,
    input  wsp_pkg::byte_item_t   byte_item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  wsp_pkg::result_item_t result_item,
    output int                    fail_count,
    output int                    outstanding,
    output int                    checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef enum logic [3:0] {
        SEEK_RIFF,
        SEEK_FMT_HDR,
        SKIP_TO_FMT,
        READ_FMT,
        SEEK_DATA_HDR,
        SKIP_TO_DATA,
        READ_SAMPLES,
        WAIT_EOF
    } parse_phase_t;

    // predicted parser state
    parse_phase_t phase;
    logic [31:0]  field_idx;
    logic [31:0]  tag_bits;
    logic [31:0]  chunk_len;
    logic [15:0]  fmt_code;
    logic [15:0]  chans;
    logic [31:0]  rate;
    logic [15:0]  bits;
    logic [7:0]   low_byte;
    logic         chan_toggle;
    logic [31:0]  data_left;

    wsp_pkg::result_item_t expected_results[$];
    int                    fails;
    int                    checked;

    function automatic void clear_parser();
        phase       = SEEK_RIFF;
        field_idx   = '0;
        tag_bits    = '0;
        chunk_len   = '0;
        fmt_code    = '0;
        chans       = '0;
        rate        = '0;
        bits        = '0;
        low_byte    = '0;
        chan_toggle = 1'b0;
        data_left   = '0;
    endfunction

    // chunk header: four tag bytes then a little-endian length, true on the eighth
    function automatic bit take_header_byte(input logic [7:0] b);
        logic [31:0] k;
        k = field_idx;
        if (k == 0)
            chunk_len = '0;
        if (k < 4)
            tag_bits = {tag_bits[23:0], b};
        else
            chunk_len = chunk_len | (32'(b) << (8 * k[1:0]));
        field_idx = k + 1;
        return k >= 7;
    endfunction

    // skip a chunk body, field_idx holds the pad flag
    function automatic void start_skip(input parse_phase_t skip_ph,
                                       input parse_phase_t next_ph,
                                       input logic [31:0] len, input logic pad);
        field_idx = '0;
        if (len == 0 && !pad)
        begin
            phase = next_ph;
        end
        else
        begin
            phase     = skip_ph;
            chunk_len = len;
            field_idx = {31'd0, pad};
        end
    endfunction

    function automatic void skip_one(input parse_phase_t next_ph);
        if (chunk_len > 0)
            chunk_len = chunk_len - 1;
        else
            field_idx = '0;
        if (chunk_len == 0 && field_idx == 0)
            phase = next_ph;
    endfunction

    // one byte of the file through the parser, at most one result
    function automatic void parse_byte(input wsp_pkg::byte_item_t item, output bit fires,
                                       output wsp_pkg::result_item_t res);
        logic [7:0]  b;
        logic [31:0] k;
        logic        ready;
        logic [15:0] value;
        b     = item.data_byte;
        k     = field_idx;
        fires = 1'b0;
        res   = '0;
        ready = 1'b0;
        value = '0;
        case (phase)
            SEEK_RIFF:
            begin
                tag_bits  = {tag_bits[23:0], b};
                field_idx = k + 1;
                if ((k == 3 && tag_bits != wsp_pkg::TAG_RIFF) ||
                    (k == 11 && tag_bits != wsp_pkg::TAG_WAVE))
                begin
                    fires      = 1'b1;
                    res.status = wsp_pkg::ST_BAD_RIFF;
                    phase      = WAIT_EOF;
                end
                else if (k >= 11)
                begin
                    phase     = SEEK_FMT_HDR;
                    field_idx = '0;
                end
            end
            SEEK_FMT_HDR:
            begin
                if (take_header_byte(b))
                begin
                    if (tag_bits == wsp_pkg::TAG_FMT)
                    begin
                        phase     = READ_FMT;
                        field_idx = '0;
                    end
                    else
                    begin
                        start_skip(SKIP_TO_FMT, SEEK_FMT_HDR, chunk_len, chunk_len[0]);
                    end
                end
            end
            SKIP_TO_FMT:
            begin
                skip_one(SEEK_FMT_HDR);
            end
            READ_FMT:
            begin
                case (k)
                    0:       fmt_code = {8'h00, b};
                    1:       fmt_code[15:8] = b;
                    2:       chans = {8'h00, b};
                    3:       chans[15:8] = b;
                    4:       rate = {24'd0, b};
                    5:       rate[15:8] = b;
                    6:       rate[23:16] = b;
                    7:       rate[31:24] = b;
                    14:      bits = {8'h00, b};
                    15:      bits[15:8] = b;
                    default: ;
                endcase
                field_idx = k + 1;
                if (k >= 15)
                begin
                    if (fmt_code != wsp_pkg::PCM_CODE)
                    begin
                        fires      = 1'b1;
                        res.status = wsp_pkg::ST_NOT_PCM;
                        phase      = WAIT_EOF;
                    end
                    else if (chunk_len > wsp_pkg::FMT_BODY_LEN)
                    begin
                        // extra fmt bytes and their pad
                        start_skip(SKIP_TO_DATA, SEEK_DATA_HDR,
                                   chunk_len - wsp_pkg::FMT_BODY_LEN, chunk_len[0]);
                    end
                    else
                    begin
                        phase     = SEEK_DATA_HDR;
                        field_idx = '0;
                    end
                end
            end
            SEEK_DATA_HDR:
            begin
                if (take_header_byte(b))
                begin
                    if (tag_bits != wsp_pkg::TAG_DATA)
                    begin
                        start_skip(SKIP_TO_DATA, SEEK_DATA_HDR, chunk_len, chunk_len[0]);
                    end
                    else if (chunk_len == 0)
                    begin
                        fires      = 1'b1;
                        res.status = wsp_pkg::ST_EMPTY_DATA;
                        phase      = WAIT_EOF;
                    end
                    else if (bits != wsp_pkg::BITS_NARROW && bits != wsp_pkg::BITS_WIDE)
                    begin
                        fires      = 1'b1;
                        res.status = wsp_pkg::ST_BAD_BITS;
                        phase      = WAIT_EOF;
                    end
                    else if (chans != wsp_pkg::CH_MONO && chans != wsp_pkg::CH_STEREO)
                    begin
                        fires      = 1'b1;
                        res.status = wsp_pkg::ST_BAD_CHANNELS;
                        phase      = WAIT_EOF;
                    end
                    else
                    begin
                        // a trailing odd byte of wide data carries no sample
                        data_left   = (bits == wsp_pkg::BITS_WIDE) ?
                                      {chunk_len[31:1], 1'b0} : chunk_len;
                        chan_toggle = 1'b0;
                        field_idx   = '0;
                        phase       = (data_left != 0) ? READ_SAMPLES : WAIT_EOF;
                        fires            = 1'b1;
                        res.status       = wsp_pkg::ST_HEADER_OK;
                        res.sample_rate  = rate;
                        res.num_channels = chans[1:0];
                        res.sample_bits  = bits[4:0];
                    end
                end
            end
            SKIP_TO_DATA:
            begin
                skip_one(SEEK_DATA_HDR);
            end
            READ_SAMPLES:
            begin
                // narrow samples are offset binary, wide ones little-endian signed
                if (bits == wsp_pkg::BITS_NARROW)
                begin
                    value = {b ^ 8'h80, 8'h00};
                    ready = 1'b1;
                end
                else if (field_idx == 0)
                begin
                    low_byte  = b;
                    field_idx = 32'd1;
                end
                else
                begin
                    value     = {b, low_byte};
                    field_idx = '0;
                    ready     = 1'b1;
                end
                if (ready)
                begin
                    fires             = 1'b1;
                    res.status        = wsp_pkg::ST_SAMPLE;
                    res.sample_value  = value;
                    res.channel_index = chan_toggle;
                    if (chans == wsp_pkg::CH_STEREO)
                        chan_toggle = ~chan_toggle;
                end
                if (data_left > 0)
                    data_left = data_left - 1;
                if (data_left == 0)
                    phase = WAIT_EOF;
            end
            default:
            begin
                phase = WAIT_EOF;
            end
        endcase

        // end mark: report where the file stopped short, then restart
        if (item.end_of_file)
        begin
            if (!fires)
            begin
                if (phase == SEEK_RIFF)
                begin
                    fires      = 1'b1;
                    res.status = wsp_pkg::ST_BAD_RIFF;
                end
                else if (phase == SEEK_FMT_HDR || phase == SKIP_TO_FMT || phase == READ_FMT)
                begin
                    fires      = 1'b1;
                    res.status = wsp_pkg::ST_NO_FMT;
                end
                else if (phase == SEEK_DATA_HDR || phase == SKIP_TO_DATA)
                begin
                    fires      = 1'b1;
                    res.status = wsp_pkg::ST_NO_DATA;
                end
            end
            clear_parser();
        end
    endfunction

    // predict on accepted bytes, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        bit                    fires;
        wsp_pkg::result_item_t want;
        wsp_pkg::result_item_t got;
        if (!rst_n)
        begin
            clear_parser();
            expected_results.delete();
            fails = 0;
            checked = 0;
            fail_count    <= 0;
            outstanding   <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                parse_byte(byte_item, fires, want);
                if (fires)
                    expected_results.push_back(want);
            end
            if (result_valid && !result_stall)
            begin
                got = result_item;
                if (expected_results.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display(
                            "%0t: unexpected st %0d val %0d ch %0d rate %0h nch %0d bits %0d",
                            $time, got.status, got.sample_value, got.channel_index,
                            got.sample_rate, got.num_channels, got.sample_bits);
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.status !== want.status || got.sample_value !== want.sample_value ||
                        got.channel_index !== want.channel_index ||
                        got.sample_rate !== want.sample_rate ||
                        got.num_channels !== want.num_channels ||
                        got.sample_bits !== want.sample_bits)
                    begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                        begin
                            $display(
                                "%0t: expected st %0d val %0d ch %0d rate %0h nch %0d bits %0d",
                                $time, want.status, want.sample_value, want.channel_index,
                                want.sample_rate, want.num_channels, want.sample_bits);
                            $display(
                                "%0t:      got st %0d val %0d ch %0d rate %0h nch %0d bits %0d",
                                $time, got.status, got.sample_value, got.channel_index,
                                got.sample_rate, got.num_channels, got.sample_bits);
                        end
                    end
                end
            end
            fail_count    <= fails;
            outstanding   <= expected_results.size();
            checked_count <= checked;
        end
    end

endmodule

@@ tb/tb_wav_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tb_wav_stream_parser_unit: testbench of the wav stream parser
// Feeds short wav files byte by byte, well-formed pcm streams with random
// content mixed with foreign chunks, bad headers, noise and early end marks,
// under random gaps and result stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_wav_stream_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_BYTES = 1800;
    localparam int          DRAIN_EVERY  = 6;
    localparam int          DRAIN_CYCLES = 32;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam logic [31:0] TAG_LIST     = 32'h4C49_5354;
    localparam logic [31:0] TAG_RIFX     = 32'h5249_4658;
    localparam logic [31:0] TAG_WAVF     = 32'h5741_5646;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    wsp_pkg::byte_item_t   byte_item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    wsp_pkg::result_item_t result_item;

    int           fail_count;
    int           outstanding;
    int           checked_count;
    int           cycle_count = 0;
    int           bytes_sent = 0;
    int           file_count = 0;
    int           rx_hold = 0;
    bit           tx_quiet = 1'b0;
    bit           rx_quiet = 1'b0;
    logic [7:0]   wav_bytes[$];

    wav_stream_parser_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    wav_stream_parser_check u_parse_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_item     (byte_item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_item   (result_item),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // receiver: after each taken transaction, stall the next one a random while
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
            rx_hold = rx_quiet ? 0 : int'($urandom_range(0, 6));
        else if (result_valid && rx_hold > 0)
            rx_hold--;
        result_stall <= (rx_hold > 0);
    end

    // file building: little-endian fields, tags in arrival order
    function automatic void add_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            wav_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void add_tag(input logic [31:0] tag);
        add_le({tag[7:0], tag[15:8], tag[23:16], tag[31:24]}, 4);
    endfunction

    // random bytes, leaning on the extreme sample codes
    function automatic void add_noise(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:       wav_bytes.push_back(8'h00);
                1:       wav_bytes.push_back(8'hFF);
                2:       wav_bytes.push_back(8'h80);
                3:       wav_bytes.push_back(8'h7F);
                default: wav_bytes.push_back(8'($urandom()));
            endcase
        end
    endfunction

    // chunk the parser has to skip; a huge length swallows the rest of the file
    function automatic void add_side_chunk(input logic [31:0] tag);
        logic [31:0] len;
        len = ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 7));
        add_tag(tag);
        add_le(len, 4);
        if (len == 32'hFFFF_FFFF)
        begin
            add_noise(int'($urandom_range(1, 12)));
        end
        else
        begin
            add_noise(int'(len));
            if (len[0])
                add_noise(1);
        end
    endfunction

    function automatic logic [31:0] side_tag(input bit fmt_allowed);
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       return wsp_pkg::TAG_DATA;
            1:       return fmt_allowed ? wsp_pkg::TAG_FMT : TAG_LIST;
            2:       return $urandom();
            default: return TAG_LIST;
        endcase
    endfunction

    function automatic void build_wav_file();
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        int          pick;
        wav_bytes.delete();

        // pure noise, sometimes behind a good riff tag
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                add_tag(wsp_pkg::TAG_RIFF);
            add_noise(int'($urandom_range(1, 10)));
            return;
        end

        // format fields, mostly legal
        code = ($urandom_range(0, 15) == 0) ? 16'($urandom()) : wsp_pkg::PCM_CODE;
        pick = $urandom_range(0, 24);
        case (pick)
            0:       chans = 16'd0;
            1:       chans = 16'd3;
            2:       chans = 16'hFFFF;
            default: chans = ($urandom_range(0, 1) == 0) ? wsp_pkg::CH_MONO : wsp_pkg::CH_STEREO;
        endcase
        pick = $urandom_range(0, 24);
        case (pick)
            0:       bits = 16'd0;
            1:       bits = 16'd24;
            2:       bits = 16'hFFFF;
            3:       bits = 16'h0108;
            default: bits = ($urandom_range(0, 1) == 0) ?
                            wsp_pkg::BITS_NARROW : wsp_pkg::BITS_WIDE;
        endcase
        pick = $urandom_range(0, 5);
        case (pick)
            0:       rate = 32'd0;
            1:       rate = 32'hFFFF_FFFF;
            2:       rate = 32'd44100;
            default: rate = $urandom();
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0:       fmt_len = 32'($urandom_range(0, 15));
            1, 2:    fmt_len = wsp_pkg::FMT_BODY_LEN + 32'($urandom_range(1, 6));
            default: fmt_len = wsp_pkg::FMT_BODY_LEN;
        endcase
        pick = $urandom_range(0, 19);
        case (pick)
            0:       data_len = 32'd0;
            1:       data_len = 32'd1;
            2:       data_len = 32'hFFFF_FFFF;
            default: data_len = 32'($urandom_range(2, 24));
        endcase

        // riff header
        add_tag(wsp_pkg::TAG_RIFF);
        add_le($urandom(), 4);
        add_tag(wsp_pkg::TAG_WAVE);

        // foreign chunks ahead of fmt
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_side_chunk(side_tag(1'b0));

        // fmt chunk, extra bytes padded to even length
        add_tag(wsp_pkg::TAG_FMT);
        add_le(fmt_len, 4);
        add_le(32'(code), 2);
        add_le(32'(chans), 2);
        add_le(rate, 4);
        add_le($urandom(), 4);
        add_le($urandom(), 2);
        add_le(32'(bits), 2);
        if (fmt_len > wsp_pkg::FMT_BODY_LEN)
        begin
            add_noise(int'(fmt_len - wsp_pkg::FMT_BODY_LEN));
            if (fmt_len[0])
                add_noise(1);
        end

        // foreign chunks ahead of data, at times a second fmt among them
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_side_chunk(side_tag(1'b1));

        // data chunk, an endless one is cut by the end mark
        add_tag(wsp_pkg::TAG_DATA);
        add_le(data_len, 4);
        add_noise((data_len > 24) ? int'($urandom_range(1, 30)) : int'(data_len));

        // trailing bytes ignored up to the end mark
        if ($urandom_range(0, 3) == 0)
            add_noise(int'($urandom_range(1, 4)));

        // damage a byte, or stop the file early
        if ($urandom_range(0, 19) == 0)
            wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom());
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, wav_bytes.size() - 1)) void'(wav_bytes.pop_back());
    endfunction

    // one byte transaction, preceded by a random gap
    task automatic push_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = tx_quiet ? 0 : int'($urandom_range(0, 6));
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= '{data_byte: b, end_of_file: eof};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // whole file with the end mark on its last byte
    task automatic send_file();
        foreach (wav_bytes[i])
            push_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        file_count++;
    endtask

    // hold the sender until every predicted result has come out
    task automatic wait_for_drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        int start_bytes;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte files at both byte extremes
        wav_bytes = '{8'h00};
        send_file();
        wav_bytes = '{8'hFF};
        send_file();
        // bad riff tag, then a byte ignored up to the end mark
        wav_bytes.delete();
        add_tag(TAG_RIFX);
        add_noise(1);
        send_file();
        // good riff tag, bad wave tag ending the file
        wav_bytes.delete();
        add_tag(wsp_pkg::TAG_RIFF);
        add_le(32'hFFFF_FFFF, 4);
        add_tag(TAG_WAVF);
        send_file();
        wait_for_drain();

        // random files
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            build_wav_file();
            send_file();
            if (file_count % DRAIN_EVERY == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d files in %0d byte transactions, %0d result transactions checked",
                 file_count, bytes_sent, checked_count);
        $display("files mixed pcm streams, foreign chunks, header errors, noise and cut-offs");
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
